@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is asserted.
`define ASSERT_RST(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");

// Assertion that is also checked during reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

@@ rtl/hms_pkg.sv @@
// ----------------------------------------------------------------------------
// hms_pkg
// Shared types, codes and constants of the heater mode selector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hms_pkg;

  localparam int unsigned TempW  = 20;
  localparam int unsigned GoalW  = 12;
  localparam int unsigned MagW   = 11;
  localparam int unsigned CeilW  = 8;
  localparam int unsigned ShiftW = 4;
  localparam int unsigned RateW  = 16;
  localparam int unsigned CfgIdxW = 3;

  // mode codes
  localparam logic [1:0] MODE_IDLE     = 2'd0;
  localparam logic [1:0] MODE_COOL     = 2'd1;
  localparam logic [1:0] MODE_WARM     = 2'd2;
  localparam logic [1:0] MODE_MAINTAIN = 2'd3;

  // active loop codes
  localparam logic [1:0] LOOP_NONE = 2'd0;
  localparam logic [1:0] LOOP_RATE = 2'd1;
  localparam logic [1:0] LOOP_ABS  = 2'd2;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_SET_TEMP   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MANUAL     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_TEMP_SHIFT = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_RATE_SHIFT = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_RATE_MIN   = 3'd4;

  // thresholds, Q13.8
  localparam logic signed [21:0] T_HOT          = 22'sd23040;
  localparam logic signed [21:0] T_COOL_MIN     = 22'sd7680;
  localparam logic signed [21:0] T_MAINTAIN_MIN = 22'sd12800;
  localparam logic signed [21:0] T_BAND         = 22'sd512;
  localparam logic signed [21:0] T_REWARM       = 22'sd2560;

  localparam logic [CeilW-1:0] CEIL_LOW  = 8'd100;
  localparam logic [CeilW-1:0] CEIL_HIGH = 8'd255;

  // (x + 30) / 60 as x * ceil(2^22 / 60) >> 22, exact for x up to 74898
  localparam logic [16:0] RECIP_60   = 17'd69906;
  localparam int unsigned RECIP_SHIFT = 22;
  localparam logic [16:0] ROUND_HALF = 17'd30;

  // controls handed from mode logic to the result register
  typedef struct packed {
    logic [1:0]       mode;
    logic             entered;
    logic [GoalW-1:0] goal;
    logic [CeilW-1:0] ceil;
    logic [1:0]       loop;
  } hms_mode_t;

endpackage

`default_nettype wire

@@ rtl/hms_filter.sv @@
// ----------------------------------------------------------------------------
// hms_filter
// Exponential averages of temperature and of its step-to-step change.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hms_filter (
  input  wire logic signed [hms_pkg::TempW-1:0]  sample_i,
  input  wire logic signed [hms_pkg::TempW-1:0]  temp_avg_i,
  input  wire logic signed [hms_pkg::TempW-1:0]  rate_avg_i,
  input  wire logic        [hms_pkg::ShiftW-1:0] temp_shift_i,
  input  wire logic        [hms_pkg::ShiftW-1:0] rate_shift_i,
  output logic signed      [hms_pkg::TempW-1:0]  temp_avg_o,
  output logic signed      [hms_pkg::TempW-1:0]  rate_avg_o
);
  import hms_pkg::*;

  logic signed [TempW:0]   diff;
  logic signed [TempW:0]   step;
  logic signed [TempW:0]   tsum;
  logic signed [TempW:0]   dlt;
  logic signed [TempW:0]   rstep;
  logic signed [TempW-1:0] rdecay;
  logic signed [TempW+1:0] rsum;

  always_comb begin
    diff  = {sample_i[TempW-1], sample_i} - {temp_avg_i[TempW-1], temp_avg_i};
    step  = diff >>> temp_shift_i;  // arithmetic shift is floor division
    tsum  = {temp_avg_i[TempW-1], temp_avg_i} + step;
    temp_avg_o = tsum[TempW-1:0];

    dlt    = {temp_avg_o[TempW-1], temp_avg_o} - {temp_avg_i[TempW-1], temp_avg_i};
    rstep  = dlt >>> rate_shift_i;
    rdecay = rate_avg_i >>> rate_shift_i;
    rsum   = {{2{rate_avg_i[TempW-1]}}, rate_avg_i} + {rstep[TempW], rstep}
           - {{2{rdecay[TempW-1]}}, rdecay};

    if (temp_avg_i == '0) begin
      rate_avg_o = rate_avg_i;
    end else if (rsum > 22'sd524287) begin
      rate_avg_o = 20'sh7FFFF;
    end else if (rsum < -22'sd524288) begin
      rate_avg_o = 20'sh80000;
    end else begin
      rate_avg_o = rsum[TempW-1:0];
    end
  end

endmodule

`default_nettype wire

@@ rtl/hms_mode.sv @@
// ----------------------------------------------------------------------------
// hms_mode
// Threshold rules with hysteresis and mode entry actions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hms_mode (
  input  wire logic signed [hms_pkg::TempW-1:0] temp_i,
  input  wire logic signed [hms_pkg::TempW-1:0] set_temp_i,
  input  wire logic                             manual_i,
  input  wire logic        [1:0]                mode_i,
  input  wire logic        [hms_pkg::GoalW-1:0] goal_i,
  input  wire logic        [hms_pkg::CeilW-1:0] ceil_i,
  input  wire logic        [hms_pkg::MagW-1:0]  mag_i,
  output hms_pkg::hms_mode_t                    res_o
);
  import hms_pkg::*;

  logic signed [21:0] t;
  logic signed [21:0] s;
  logic signed [21:0] sd;
  logic        [1:0]  nxt;
  logic        [GoalW-1:0] mag_ext;

  always_comb begin
    t   = {{2{temp_i[TempW-1]}}, temp_i};
    s   = {{2{set_temp_i[TempW-1]}}, set_temp_i};
    sd  = s - t;
    nxt = mode_i;
    mag_ext = {1'b0, mag_i};
    if (manual_i) begin
      nxt = MODE_IDLE;
    end else begin
      // later rules override earlier ones
      if (t > T_HOT && s < T_HOT) nxt = MODE_IDLE;
      if (s > t + T_BAND && t < T_HOT && mode_i != MODE_MAINTAIN) nxt = MODE_WARM;
      if (s > t + T_REWARM && t < T_HOT && mode_i == MODE_MAINTAIN) nxt = MODE_WARM;
      if (s < t - T_BAND && t >= T_COOL_MIN) nxt = MODE_COOL;
      if (s > T_MAINTAIN_MIN && sd <= T_BAND && sd >= -T_BAND &&
          mode_i != MODE_MAINTAIN) nxt = MODE_MAINTAIN;
    end

    res_o.mode    = nxt;
    res_o.entered = (nxt != mode_i);
    res_o.goal    = goal_i;
    res_o.ceil    = ceil_i;
    if (res_o.entered) begin
      case (nxt)
        MODE_IDLE: res_o.ceil = CEIL_HIGH;
        MODE_WARM: begin
          res_o.ceil = CEIL_HIGH;
          res_o.goal = mag_ext;
        end
        MODE_COOL: res_o.goal = -mag_ext;
        default: ;
      endcase
    end

    case (nxt)
      MODE_IDLE:     res_o.loop = LOOP_NONE;
      MODE_MAINTAIN: res_o.loop = LOOP_ABS;
      default:       res_o.loop = LOOP_RATE;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/heater_mode_selector_with_filters_top.sv @@
// An accepted sample beat goes to the input register, then through the filters
// and mode rules in one pass into the result register, which a stall holds.
// Throughput: one sample per cycle while the output is not stalled.
// Reset clears both filters, sets mode idle, rate target 0, ceiling 100,
// and loads the register reset values (manual mode on, shifts 3).
// ----------------------------------------------------------------------------
// heater_mode_selector_with_filters_top
// Temperature and rate filters feeding a four-mode heater selector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module heater_mode_selector_with_filters_top (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic        [hms_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic        [hms_pkg::TempW-1:0]   cfg_wdata_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic signed [hms_pkg::TempW-1:0]   temperature_sample_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic             [1:0]                  state_now_o,
  output logic                                    entered_o,
  output logic signed      [hms_pkg::TempW-1:0]   temperature_o,
  output logic signed      [hms_pkg::TempW-1:0]   temperature_rate_o,
  output logic signed      [hms_pkg::GoalW-1:0]   rate_target_o,
  output logic             [1:0]                  active_loop_o,
  output logic             [hms_pkg::CeilW-1:0]   rate_limit_high_o
);
  import hms_pkg::*;

  // configuration
  logic signed [TempW-1:0]  set_temp_q;
  logic                     manual_q;
  logic        [ShiftW-1:0] tshift_q;
  logic        [ShiftW-1:0] rshift_q;
  logic        [RateW-1:0]  rpm_q;
  logic        [MagW-1:0]   mag_d;
  logic        [33:0]       mag_prod;

  // block state
  logic signed [TempW-1:0]  tavg_q;
  logic signed [TempW-1:0]  ravg_q;
  logic        [1:0]        mode_q;
  logic        [GoalW-1:0]  goal_q;
  logic        [CeilW-1:0]  ceil_q;

  // pipeline
  logic                     s1_valid_q;
  logic signed [TempW-1:0]  s1_sample_q;
  logic                     out_valid_q;
  logic                     in_acc, adv;

  logic signed [TempW-1:0]  tavg_d, ravg_d;
  hms_mode_t                mres;

  assign adv        = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  // ramp magnitude, straight from the register
  always_comb begin
    mag_prod = ({1'b0, rpm_q} + ROUND_HALF) * RECIP_60;
    mag_d    = mag_prod[RECIP_SHIFT +: MagW];
  end

  hms_filter u_filter (
    .sample_i     (s1_sample_q),
    .temp_avg_i   (tavg_q),
    .rate_avg_i   (ravg_q),
    .temp_shift_i (tshift_q),
    .rate_shift_i (rshift_q),
    .temp_avg_o   (tavg_d),
    .rate_avg_o   (ravg_d)
  );

  hms_mode u_mode (
    .temp_i     (tavg_d),
    .set_temp_i (set_temp_q),
    .manual_i   (manual_q),
    .mode_i     (mode_q),
    .goal_i     (goal_q),
    .ceil_i     (ceil_q),
    .mag_i      (mag_d),
    .res_o      (mres)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_temp_q  <= '0;
      manual_q    <= 1'b1;
      tshift_q    <= 4'd3;
      rshift_q    <= 4'd3;
      rpm_q       <= '0;
      tavg_q      <= '0;
      ravg_q      <= '0;
      mode_q      <= MODE_IDLE;
      goal_q      <= '0;
      ceil_q      <= CEIL_LOW;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SET_TEMP:   set_temp_q <= cfg_wdata_i;
          CFG_MANUAL:     manual_q   <= cfg_wdata_i[0];
          CFG_TEMP_SHIFT: tshift_q   <= cfg_wdata_i[ShiftW-1:0];
          CFG_RATE_SHIFT: rshift_q   <= cfg_wdata_i[ShiftW-1:0];
          CFG_RATE_MIN:   rpm_q      <= cfg_wdata_i[RateW-1:0];
          default: ;
        endcase
      end
      if (adv) begin
        tavg_q <= tavg_d;
        ravg_q <= ravg_d;
        mode_q <= mres.mode;
        goal_q <= mres.goal;
        ceil_q <= mres.ceil;
      end
      s1_valid_q  <= in_acc || (s1_valid_q && !adv);
      out_valid_q <= adv || (out_valid_q && out_stall_i);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_sample_q <= temperature_sample_i;
    end
    if (adv) begin
      state_now_o        <= mres.mode;
      entered_o          <= mres.entered;
      temperature_o      <= tavg_d;
      temperature_rate_o <= ravg_d;
      rate_target_o      <= mres.goal;
      active_loop_o      <= mres.loop;
      rate_limit_high_o  <= mres.ceil;
    end
  end

endmodule

`default_nettype wire

@@ rtl/hms_checker.sv @@
// ----------------------------------------------------------------------------
// hms_checker
// Port-level checks of the heater mode selector, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module hms_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               out_valid_o,
  input wire logic                               out_stall_i,
  input wire logic        [1:0]                  state_now_o,
  input wire logic signed [hms_pkg::TempW-1:0]   temperature_o,
  input wire logic signed [hms_pkg::GoalW-1:0]   rate_target_o,
  input wire logic        [1:0]                  active_loop_o,
  input wire logic        [hms_pkg::CeilW-1:0]   rate_limit_high_o
);
  import hms_pkg::*;

  // no result beat while in reset
  `ASSERT_ALWAYS(a_no_out_in_reset, clk_i, !rst_ni |-> !out_valid_o)

  // a stalled result beat stays
  `ASSERT_RST(a_out_hold, clk_i, rst_ni,
              out_valid_o && out_stall_i |=> out_valid_o && $stable(temperature_o))

  // active loop follows the mode
  `ASSERT_RST(a_loop_mode, clk_i, rst_ni,
              out_valid_o |-> (state_now_o == MODE_IDLE && active_loop_o == LOOP_NONE) ||
                              (state_now_o == MODE_MAINTAIN && active_loop_o == LOOP_ABS) ||
                              (state_now_o == MODE_COOL && active_loop_o == LOOP_RATE) ||
                              (state_now_o == MODE_WARM && active_loop_o == LOOP_RATE))

  // ceiling only ever takes its two values, target stays in range
  `ASSERT_RST(a_ceil_target, clk_i, rst_ni,
              out_valid_o |-> (rate_limit_high_o == CEIL_LOW ||
                               rate_limit_high_o == CEIL_HIGH) &&
                              rate_target_o <= 12'sd1093 && rate_target_o >= -12'sd1093)

endmodule

bind heater_mode_selector_with_filters_top hms_checker u_hms_checker (.*);

`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the heater mode selector. A short list of directed
// samples and register writes is followed by random setpoint phases with
// wandering temperatures. Every status beat is checked field by field against
// given values or an in-bench model of the filters and mode rules.
// ----------------------------------------------------------------------------

module tb_top;

  import hms_pkg::*;

  localparam int RANDOM_ITEMS = 1400;
  localparam int QUIET_ITEMS  = 150;

  localparam longint Q8_MAX       = 524287;
  localparam longint Q8_MIN       = -524288;
  localparam longint HOT_Q8       = 90 * 256;
  localparam longint COOL_MIN_Q8  = 30 * 256;
  localparam longint WARM_HOLD_Q8 = 50 * 256;
  localparam longint BAND_Q8      = 2 * 256;
  localparam longint REWARM_Q8    = 10 * 256;
  localparam logic [CeilW-1:0] CEIL_FIRST = 8'd100;
  localparam logic [CeilW-1:0] CEIL_FULL  = 8'd255;

  localparam logic [CfgIdxW-1:0] IDX_SPARE_LO = CFG_RATE_MIN + 1'b1;
  localparam logic [CfgIdxW-1:0] IDX_SPARE_HI = '1;

  typedef struct packed {
    logic [1:0]              mode;
    logic                    entered;
    logic signed [TempW-1:0] temp;
    logic signed [TempW-1:0] rate;
    logic signed [GoalW-1:0] goal;
    logic [1:0]              loop;
    logic [CeilW-1:0]        ceil;
  } heater_status_t;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} plan_kind_e;

  typedef struct {
    plan_kind_e          kind;
    logic [CfgIdxW-1:0]  idx;
    logic [TempW-1:0]    value;
    bit                  known;
    heater_status_t      want;
  } plan_row_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [CfgIdxW-1:0]        cfg_idx_i;
  logic [TempW-1:0]          cfg_wdata_i;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic signed [TempW-1:0]   temperature_sample_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic [1:0]                state_now_o;
  logic                      entered_o;
  logic signed [TempW-1:0]   temperature_o;
  logic signed [TempW-1:0]   temperature_rate_o;
  logic signed [GoalW-1:0]   rate_target_o;
  logic [1:0]                active_loop_o;
  logic [CeilW-1:0]          rate_limit_high_o;

  heater_mode_selector_with_filters_top u_top (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .temperature_sample_i (temperature_sample_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .state_now_o          (state_now_o),
    .entered_o            (entered_o),
    .temperature_o        (temperature_o),
    .temperature_rate_o   (temperature_rate_o),
    .rate_target_o        (rate_target_o),
    .active_loop_o        (active_loop_o),
    .rate_limit_high_o    (rate_limit_high_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model registers and state
  longint           set_point_q8 = 0;
  bit               manual_on    = 1'b1;
  int unsigned      temp_shift   = 3;
  int unsigned      rate_shift   = 3;
  int unsigned      ramp_per_min = 0;
  longint           temp_avg_q8  = 0;
  longint           rate_avg_q8  = 0;
  logic [1:0]       mode_now     = MODE_IDLE;
  longint           goal_q8      = 0;
  logic [CeilW-1:0] ceil_now     = CEIL_FIRST;

  heater_status_t status_q[$];
  plan_row_t      plan_q[$];
  bit             quiet_tail = 1'b0;
  int             mismatches = 0;
  int             samples_sent = 0;
  int             reg_writes = 0;
  int             beats_checked = 0;
  int             entry_cnt[4] = '{0, 0, 0, 0};

  function automatic logic signed [TempW-1:0] clamp_q8(input longint v);
    if (v > Q8_MAX) v = Q8_MAX;
    else if (v < Q8_MIN) v = Q8_MIN;
    return v[TempW-1:0];
  endfunction

  function automatic void apply_reg(input logic [CfgIdxW-1:0] idx,
                                    input logic [TempW-1:0] data);
    case (idx)
      CFG_SET_TEMP:   set_point_q8 = longint'($signed(data));
      CFG_MANUAL:     manual_on    = data[0];
      CFG_TEMP_SHIFT: temp_shift   = 32'(data[ShiftW-1:0]);
      CFG_RATE_SHIFT: rate_shift   = 32'(data[ShiftW-1:0]);
      CFG_RATE_MIN:   ramp_per_min = 32'(data[RateW-1:0]);
      default: ;
    endcase
  endfunction

  // advance filters and mode rules by one sample; returns the status beat
  function automatic heater_status_t advance_heater(input logic signed [TempW-1:0] sample);
    longint         old_avg, t, s, gap, mag, rate_sum;
    logic [1:0]     nxt;
    heater_status_t st;
    old_avg = temp_avg_q8;
    // >>> on signed longint is floor division by 2^s
    temp_avg_q8 = old_avg + ((longint'(sample) - old_avg) >>> temp_shift);
    if (old_avg != 0) begin
      rate_sum = rate_avg_q8 + ((temp_avg_q8 - old_avg) >>> rate_shift)
                 - (rate_avg_q8 >>> rate_shift);
      if (rate_sum > Q8_MAX) rate_sum = Q8_MAX;
      else if (rate_sum < Q8_MIN) rate_sum = Q8_MIN;
      rate_avg_q8 = rate_sum;
    end
    t = temp_avg_q8;
    s = set_point_q8;
    nxt = mode_now;
    if (manual_on) begin
      nxt = MODE_IDLE;
    end else begin
      // later rules override earlier ones
      if (t > HOT_Q8 && s < HOT_Q8) nxt = MODE_IDLE;
      if (s > t + BAND_Q8 && t < HOT_Q8 && mode_now != MODE_MAINTAIN) nxt = MODE_WARM;
      if (s > t + REWARM_Q8 && t < HOT_Q8 && mode_now == MODE_MAINTAIN) nxt = MODE_WARM;
      if (s < t - BAND_Q8 && t >= COOL_MIN_Q8) nxt = MODE_COOL;
      gap = (s > t) ? s - t : t - s;
      if (s > WARM_HOLD_Q8 && gap <= BAND_Q8 && mode_now != MODE_MAINTAIN)
        nxt = MODE_MAINTAIN;
    end
    st.entered = (nxt != mode_now);
    mode_now = nxt;
    if (st.entered) begin
      entry_cnt[nxt]++;
      mag = (longint'(ramp_per_min) + 30) / 60;  // per minute to per second, rounded
      case (nxt)
        MODE_IDLE: ceil_now = CEIL_FULL;
        MODE_WARM: begin
          ceil_now = CEIL_FULL;
          goal_q8 = mag;
        end
        MODE_COOL: goal_q8 = -mag;
        default: ;
      endcase
    end
    st.mode = mode_now;
    st.temp = temp_avg_q8[TempW-1:0];
    st.rate = rate_avg_q8[TempW-1:0];
    st.goal = goal_q8[GoalW-1:0];
    st.ceil = ceil_now;
    case (mode_now)
      MODE_IDLE:     st.loop = LOOP_NONE;
      MODE_MAINTAIN: st.loop = LOOP_ABS;
      default:       st.loop = LOOP_RATE;
    endcase
    return st;
  endfunction

  task automatic check_field(input string name, input longint want_v, input longint got_v);
    if (want_v != got_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
    end
  endtask

  // output monitor
  always @(posedge clk_i) begin
    heater_status_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (status_q.size() == 0) begin
        mismatches++;
        $display("%0t: status beat with nothing expected, expected none, got mode %0d",
                 $time, state_now_o);
      end else begin
        want = status_q.pop_front();
        beats_checked++;
        check_field("state_now", want.mode, state_now_o);
        check_field("entered", want.entered, entered_o);
        check_field("temperature", $signed(want.temp), $signed(temperature_o));
        check_field("temperature_rate", $signed(want.rate), $signed(temperature_rate_o));
        check_field("rate_target", $signed(want.goal), $signed(rate_target_o));
        check_field("active_loop", want.loop, active_loop_o);
        check_field("rate_limit_high", want.ceil, rate_limit_high_o);
      end
    end
  end

  // output stall: random bursts between free stretches
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (quiet_tail || !rst_ni) begin
        out_stall_i <= 1'b0;
      end else if (hold_cnt != 0) begin
        hold_cnt--;
      end else if (out_stall_i) begin
        out_stall_i <= 1'b0;
        hold_cnt = $urandom_range(0, 30);
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        hold_cnt = $urandom_range(0, 15);
      end
    end
  end

  task automatic settle();
    while (status_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TempW-1:0] data);
    in_valid_i <= 1'b0;
    settle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    apply_reg(idx, data);
    reg_writes++;
  endtask

  task automatic sender_gap();
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
  endtask

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic drive_sample(input logic signed [TempW-1:0] value, input bit known,
                              input heater_status_t want);
    heater_status_t predicted;
    in_valid_i           <= 1'b1;
    temperature_sample_i <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = advance_heater(value);
    status_q.push_back(known ? want : predicted);
    samples_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [ShiftW-1:0] pick_shift();
    if ($urandom_range(0, 3) == 0) return ShiftW'($urandom_range(9, 15));
    return ShiftW'($urandom_range(0, 8));
  endfunction

  task automatic reshuffle_regs();
    logic [TempW-1:0] junk;
    junk = TempW'($urandom);
    if ($urandom_range(0, 2) != 0) begin
      case ($urandom_range(0, 9))
        0:       write_reg(CFG_SET_TEMP, junk);
        1:       write_reg(CFG_SET_TEMP, $urandom_range(0, 1) ? 20'h7FFFF : 20'h80000);
        default: write_reg(CFG_SET_TEMP, TempW'($urandom_range(20 * 256, 110 * 256)));
      endcase
    end
    if ($urandom_range(0, 1) == 0)
      write_reg(CFG_MANUAL, {junk[TempW-1:1], ($urandom_range(0, 7) == 0)});
    if ($urandom_range(0, 2) == 0)
      write_reg(CFG_TEMP_SHIFT, {junk[TempW-1:ShiftW], pick_shift()});
    if ($urandom_range(0, 2) == 0)
      write_reg(CFG_RATE_SHIFT, {junk[TempW-1:ShiftW], pick_shift()});
    if ($urandom_range(0, 2) == 0) begin
      case ($urandom_range(0, 5))
        0:       write_reg(CFG_RATE_MIN, {junk[TempW-1:RateW], 16'h0000});
        1:       write_reg(CFG_RATE_MIN, {junk[TempW-1:RateW], 16'hFFFF});
        default: write_reg(CFG_RATE_MIN, junk);
      endcase
    end
    if ($urandom_range(0, 9) == 0)
      write_reg(CfgIdxW'($urandom_range(IDX_SPARE_LO, IDX_SPARE_HI)), junk);
  endtask

  function automatic void plan_write(input logic [CfgIdxW-1:0] idx,
                                     input logic [TempW-1:0] value);
    plan_q.push_back('{ROW_WRITE, idx, value, 1'b0, '0});
  endfunction

  function automatic void plan_sample(input logic signed [TempW-1:0] value);
    plan_q.push_back('{ROW_SAMPLE, CFG_SET_TEMP, value, 1'b0, '0});
  endfunction

  function automatic void plan_known(input logic signed [TempW-1:0] value,
                                     input heater_status_t want);
    plan_q.push_back('{ROW_SAMPLE, CFG_SET_TEMP, value, 1'b1, want});
  endfunction

  initial begin
    longint                  walk;
    logic signed [TempW-1:0] pick;
    int                      phase_len;
    int                      rand_sent;
    int                      directed_cnt;
    bit                      noisy;

    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = CFG_SET_TEMP;
    cfg_wdata_i          = '0;
    in_valid_i           = 1'b0;
    temperature_sample_i = '0;
    rand_sent            = 0;

    // reset values: manual on, shifts of 3, ceiling 100
    plan_known(20'sd0, '{MODE_IDLE, 1'b0, 20'sd0, 20'sd0, 12'sd0, LOOP_NONE, CEIL_FIRST});
    // first nonzero average: rate update skipped
    plan_known(20'sh7FFFF,
               '{MODE_IDLE, 1'b0, 20'sd65535, 20'sd0, 12'sd0, LOOP_NONE, CEIL_FIRST});
    plan_known(20'sh80000,
               '{MODE_IDLE, 1'b0, -20'sd8193, -20'sd9216, 12'sd0, LOOP_NONE, CEIL_FIRST});
    // upper bits of each write must be dropped
    plan_write(CFG_TEMP_SHIFT, 20'hFFFF0);
    plan_write(CFG_RATE_SHIFT, 20'h00000);
    plan_write(CFG_RATE_MIN, 20'hFFFFF);
    plan_write(CFG_SET_TEMP, 20'd15360);
    plan_write(CFG_MANUAL, 20'hFFFFE);
    plan_write(IDX_SPARE_LO, 20'hFFFFF);
    plan_write(IDX_SPARE_LO + 1'b1, 20'h12345);
    plan_write(IDX_SPARE_HI, 20'hFFFFF);
    plan_sample(20'sd0);            // warmup, full ramp target
    plan_sample(20'sd0);            // zero average: rate held
    plan_sample(20'sh7FFFF);        // cooldown
    plan_sample(20'sh80000);        // rate saturates low
    plan_sample(20'sh7FFFF);        // rate saturates high
    plan_sample(20'sd15360);        // maintain
    plan_sample(20'sd14360);        // inside rewarm band, hold maintain
    plan_sample(20'sd12000);        // rewarm
    plan_sample(20'sd15360);
    plan_sample(20'sd16360);        // cool from maintain
    plan_write(CFG_SET_TEMP, 20'd22784);
    plan_sample(20'sd22784);
    plan_sample(20'sd23168);        // over 90 with setpoint below: idle
    plan_write(CFG_SET_TEMP, 20'd0);
    plan_sample(20'sd5120);         // too cold for cooldown
    plan_sample(20'sd7680);         // exactly 30 C: cooldown
    plan_write(CFG_SET_TEMP, 20'h7FFFF);
    plan_sample(20'sd0);
    plan_write(CFG_SET_TEMP, 20'h80000);
    plan_sample(20'sd23041);        // cooldown overrides the overheat idle
    plan_write(CFG_TEMP_SHIFT, 20'd15);
    plan_write(CFG_RATE_SHIFT, 20'd15);
    plan_write(CFG_RATE_MIN, 20'd0);
    plan_sample(20'sh7FFFF);
    plan_sample(20'sh80000);
    plan_write(CFG_MANUAL, 20'd1);
    plan_sample(20'sd100);          // manual forces idle

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan_q[i]) begin
      if (plan_q[i].kind == ROW_WRITE) begin
        write_reg(plan_q[i].idx, plan_q[i].value);
      end else begin
        sender_gap();
        drive_sample(plan_q[i].value, plan_q[i].known, plan_q[i].want);
      end
    end
    directed_cnt = samples_sent;

    // random phases: temperature wanders around the setpoint, some noise
    while (rand_sent < RANDOM_ITEMS) begin
      reshuffle_regs();
      phase_len = $urandom_range(20, 90);
      noisy = ($urandom_range(0, 9) == 0);
      walk = set_point_q8 + longint'($urandom_range(0, 10240)) - 5120;
      repeat (phase_len) begin
        if (noisy || $urandom_range(0, 11) == 0) begin
          pick = ($urandom_range(0, 7) == 0) ? '0 : TempW'($urandom);
        end else begin
          if ($urandom_range(0, 19) == 0)
            walk = set_point_q8 + longint'($urandom_range(0, 1024)) - 512;
          else
            walk += longint'($urandom_range(0, 1536)) - 768;
          pick = clamp_q8(walk);
          walk = longint'(pick);
        end
        if (rand_sent >= RANDOM_ITEMS - QUIET_ITEMS) quiet_tail = 1'b1;
        sender_gap();
        drive_sample(pick, 1'b0, '0);
        rand_sent++;
      end
    end

    in_valid_i <= 1'b0;
    settle();
    repeat (8) @(negedge clk_i);
    $display("Covered %0d sample beats (%0d directed), %0d register writes, %0d beats checked.",
             samples_sent, directed_cnt, reg_writes, beats_checked);
    $display("Mode entries: idle %0d, cooldown %0d, warmup %0d, maintain %0d.",
             entry_cnt[MODE_IDLE], entry_cnt[MODE_COOL], entry_cnt[MODE_WARM],
             entry_cnt[MODE_MAINTAIN]);
    if (mismatches == 0 && status_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
